// ===== rtl/core/nv3_pkg.sv =====
// nv3_pkg: widths and stage counts shared by the 3d vector normaliser
// no dependencies; imported by every module of the block

package nv3_pkg;

	localparam int IN_WIDTH  = 16;
	localparam int FRAC_BITS = 14;
	localparam int OUT_WIDTH = FRAC_BITS + 2;
	// one search stage per result bit, result reaches 2^FRAC_BITS
	localparam int NSTEP     = FRAC_BITS + 1;
	localparam int K_WIDTH   = FRAC_BITS + 1;
	localparam int SUM_WIDTH = 2 * IN_WIDTH;
	// holds (2k-1)^2 * sum and the scaled square with headroom, signed
	localparam int P_WIDTH   = 2 * IN_WIDTH + 2 * FRAC_BITS + 5;
	// front stages, search stages, output register
	localparam int NSTAGE    = NSTEP + 4;

endpackage

// ===== rtl/core/nv3_front.sv =====
// nv3_front: magnitudes, squares and the exact sum of squares (three stages)
// depends on nv3_pkg

module nv3_front (
	input  logic                                       clk,
	input  logic [2:0]                                 en,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]        x_in,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]        y_in,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]        z_in,
	output logic [nv3_pkg::SUM_WIDTH-1:0]              sum_s3,
	output logic [2:0][nv3_pkg::P_WIDTH-1:0]           rhs_s3,
	output logic [2:0]                                 neg_s3,
	output logic                                       zero_s3
);
	import nv3_pkg::*;

	logic [2:0][IN_WIDTH-1:0]  raw;
	logic [2:0][IN_WIDTH-1:0]  mag_s1;
	logic [2:0]                neg_s1;
	logic [2:0][SUM_WIDTH-1:0] sq_s2;
	logic [2:0]                neg_s2;
	logic [SUM_WIDTH-1:0]      sum;

	assign raw = {z_in, y_in, x_in};
	assign sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (en[0]) begin
				neg_s1[i] <= raw[i][IN_WIDTH-1];
				// most negative input maps to 2^(IN_WIDTH-1) as unsigned
				mag_s1[i] <= raw[i][IN_WIDTH-1] ? (~raw[i] + IN_WIDTH'(1)) : raw[i];
			end
			if (en[1]) begin
				neg_s2[i] <= neg_s1[i];
				sq_s2[i]  <= SUM_WIDTH'(mag_s1[i]) * SUM_WIDTH'(mag_s1[i]);
			end
			if (en[2]) begin
				neg_s3[i] <= neg_s2[i];
				rhs_s3[i] <= P_WIDTH'(sq_s2[i]) << (2 * FRAC_BITS + 2);
			end
		end
		if (en[2]) begin
			sum_s3  <= sum;
			zero_s3 <= (sum == '0);
		end
	end

endmodule

// ===== rtl/core/nv3_lane.sv =====
// nv3_lane: one component lane, bit-per-stage search for the rounded unit value
// depends on nv3_pkg; fed by nv3_front

module nv3_lane (
	input  logic                               clk,
	input  logic [nv3_pkg::NSTEP-1:0]          en,
	input  logic [nv3_pkg::SUM_WIDTH-1:0]      sum,
	input  logic [nv3_pkg::P_WIDTH-1:0]        rhs,
	input  logic                               neg,
	output logic [nv3_pkg::K_WIDTH-1:0]        k_out,
	output logic                               neg_out
);
	import nv3_pkg::*;

	localparam logic [K_WIDTH-1:0] KMAX = K_WIDTH'(1) << FRAC_BITS;

	// p = (2k-1)^2 * sum, q = (2k-1) * sum, kept incrementally
	logic signed [P_WIDTH-1:0] p_q   [NSTEP];
	logic signed [P_WIDTH-1:0] q_q   [NSTEP];
	logic [K_WIDTH-1:0]        k_q   [NSTEP];
	logic [SUM_WIDTH-1:0]      sum_q [NSTEP];
	logic [P_WIDTH-1:0]        rhs_q [NSTEP];
	logic                      neg_q [NSTEP];

	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam int B = FRAC_BITS - j;

		logic signed [P_WIDTH-1:0] p_in, q_in, p_try, q_try, s_ext;
		logic [K_WIDTH-1:0]        k_in, k_try;
		logic [SUM_WIDTH-1:0]      s_in;
		logic [P_WIDTH-1:0]        r_in;
		logic                      n_in;
		logic                      take;

		if (j == 0) begin : g_first
			// k = 0 gives t = -1
			assign p_in = signed'(P_WIDTH'(sum));
			assign q_in = -signed'(P_WIDTH'(sum));
			assign k_in = '0;
			assign s_in = sum;
			assign r_in = rhs;
			assign n_in = neg;
		end else begin : g_next
			assign p_in = p_q[j-1];
			assign q_in = q_q[j-1];
			assign k_in = k_q[j-1];
			assign s_in = sum_q[j-1];
			assign r_in = rhs_q[j-1];
			assign n_in = neg_q[j-1];
		end

		// t grows by 2^(B+1): t'^2 = t^2 + 2^(B+2) t + 2^(2B+2)
		assign s_ext = signed'(P_WIDTH'(s_in));
		assign q_try = q_in + (s_ext <<< (B + 1));
		assign p_try = p_in + (q_in <<< (B + 2)) + (s_ext <<< (2 * B + 2));
		assign k_try = k_in + (K_WIDTH'(1) << B);
		assign take  = (k_try <= KMAX) && (p_try <= signed'(r_in));

		always_ff @(posedge clk) begin
			if (en[j]) begin
				p_q[j]   <= take ? p_try : p_in;
				q_q[j]   <= take ? q_try : q_in;
				k_q[j]   <= take ? k_try : k_in;
				sum_q[j] <= s_in;
				rhs_q[j] <= r_in;
				neg_q[j] <= n_in;
			end
		end
	end

	assign k_out   = k_q[NSTEP-1];
	assign neg_out = neg_q[NSTEP-1];

endmodule

// ===== rtl/core/vector_normalize_3d_core.sv =====
// vector_normalize_3d_core: top level, three search lanes and the merging output stage
// depends on nv3_pkg, nv3_front and nv3_lane
//
// usage
//   input channel: x_in, y_in, z_in with in_valid / in_ready; a word is taken
//   on an edge where both are high. output channel: x_out, y_out, z_out, ok
//   with out_valid / out_ready, same rule.
//   each component is scaled by 1/sqrt(x^2+y^2+z^2) to signed fixed point with
//   FRAC_BITS fraction bits, rounded to nearest with ties away from zero.
//   a zero vector gives zeros with ok low.
//   the pipeline holds three front stages, one search stage per result bit in
//   each lane, and the output register.
//   throughput is one word per cycle while the receiver takes words; every
//   stage holds its own word, so words follow one another with no gap.
//   when the receiver stalls, words pile up behind the output register and
//   empty stages keep filling, so in_ready only drops once all stages hold
//   a word.
//   reset empties the pipeline: out_valid goes low and in_ready is high.

module vector_normalize_3d_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]    x_in,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]    y_in,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]    z_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [nv3_pkg::OUT_WIDTH-1:0]   x_out,
	output logic signed [nv3_pkg::OUT_WIDTH-1:0]   y_out,
	output logic signed [nv3_pkg::OUT_WIDTH-1:0]   z_out,
	output logic                                   ok
);
	import nv3_pkg::*;

	logic [NSTAGE-1:0]           v_q;
	logic [NSTAGE-1:0]           blocked;
	logic [NSTAGE-1:0]           load;
	logic [NSTAGE-1:0]           v_prev;
	logic [SUM_WIDTH-1:0]        sum_s3;
	logic [2:0][P_WIDTH-1:0]     rhs_s3;
	logic [2:0]                  neg_s3;
	logic                        zero_s3;
	logic [NSTEP-1:0]            zero_q;
	logic [2:0][K_WIDTH-1:0]     k_fin;
	logic [2:0]                  neg_fin;
	logic [2:0][OUT_WIDTH-1:0]   res;

	// a stage is blocked when it holds a word and the one after is blocked
	always_comb begin
		blocked[NSTAGE-1] = v_q[NSTAGE-1] && !out_ready;
		for (int i = NSTAGE - 2; i >= 0; i--) begin
			blocked[i] = v_q[i] && blocked[i+1];
		end
	end

	assign load     = ~blocked;
	assign v_prev   = {v_q[NSTAGE-2:0], in_valid};
	assign in_ready = load[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NSTAGE; i++) begin
				if (load[i]) begin
					v_q[i] <= v_prev[i];
				end
			end
		end
	end

	nv3_front u_front (
		.clk     (clk),
		.en      (load[2:0]),
		.x_in    (x_in),
		.y_in    (y_in),
		.z_in    (z_in),
		.sum_s3  (sum_s3),
		.rhs_s3  (rhs_s3),
		.neg_s3  (neg_s3),
		.zero_s3 (zero_s3)
	);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		nv3_lane u_lane (
			.clk     (clk),
			.en      (load[NSTEP+2:3]),
			.sum     (sum_s3),
			.rhs     (rhs_s3[c]),
			.neg     (neg_s3[c]),
			.k_out   (k_fin[c]),
			.neg_out (neg_fin[c])
		);
	end

	// zero-vector flag rides alongside the lanes
	always_ff @(posedge clk) begin
		for (int j = 0; j < NSTEP; j++) begin
			if (load[j+3]) begin
				zero_q[j] <= (j == 0) ? zero_s3 : zero_q[(j == 0) ? 0 : j - 1];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			res[c] = neg_fin[c] ? (~OUT_WIDTH'(k_fin[c]) + OUT_WIDTH'(1))
				: OUT_WIDTH'(k_fin[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (load[NSTAGE-1]) begin
			x_out <= zero_q[NSTEP-1] ? '0 : res[0];
			y_out <= zero_q[NSTEP-1] ? '0 : res[1];
			z_out <= zero_q[NSTEP-1] ? '0 : res[2];
			ok    <= !zero_q[NSTEP-1];
		end
	end

	assign out_valid = v_q[NSTAGE-1];

endmodule

// ===== rtl/core/nv3_checker.sv =====
// nv3_checker: port-level checks on the normaliser, bound to the top level
// depends on nv3_pkg and vector_normalize_3d_core

module nv3_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]    x_in,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]    y_in,
	input  logic signed [nv3_pkg::IN_WIDTH-1:0]    z_in,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [nv3_pkg::OUT_WIDTH-1:0]   x_out,
	input  logic signed [nv3_pkg::OUT_WIDTH-1:0]   y_out,
	input  logic signed [nv3_pkg::OUT_WIDTH-1:0]   z_out,
	input  logic                                   ok
);
	import nv3_pkg::*;

	localparam logic signed [OUT_WIDTH-1:0] ONE  = OUT_WIDTH'(1) << FRAC_BITS;
	localparam logic signed [OUT_WIDTH-1:0] MONE = -ONE;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out)
			&& $stable(z_out) && $stable(ok))
		else $error("output word changed while stalled");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> x_out == '0 && y_out == '0 && z_out == '0)
		else $error("zero vector gave nonzero components");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x_out <= ONE && x_out >= MONE && y_out <= ONE && y_out >= MONE
			&& z_out <= ONE && z_out >= MONE)
		else $error("component outside unit range");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

endmodule

bind vector_normalize_3d_core nv3_checker u_nv3_checker (.*);

// ===== sim/tb_vector_normalize_3d_core.sv =====
// tb_vector_normalize_3d_core: self-checking bench for the 3d vector normaliser
// depends on nv3_pkg and vector_normalize_3d_core; exact integer rounding predictor

module tb_vector_normalize_3d_core;
	timeunit 1ns;
	timeprecision 1ps;

	import nv3_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int N_RANDOM = 1100;
	localparam logic [OUT_WIDTH-1:0] ONE_FX = OUT_WIDTH'(1) << FRAC_BITS;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] x;
		logic [OUT_WIDTH-1:0] y;
		logic [OUT_WIDTH-1:0] z;
		logic                 ok;
	} unit_vec_t;

	// directed rows: components, whether the expected word is typed in, and that word
	typedef struct {
		logic [IN_WIDTH-1:0] x;
		logic [IN_WIDTH-1:0] y;
		logic [IN_WIDTH-1:0] z;
		bit                  fixed;
		unit_vec_t           exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [IN_WIDTH-1:0] x_in = '0, y_in = '0, z_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_WIDTH-1:0] x_out, y_out, z_out;
	logic ok;
	logic stall_hold = 1'b0;

	unit_vec_t expected_words[$];
	int  errors = 0;
	int  idle_cycles = 0;
	int  words_sent = 0;
	int  words_checked = 0;
	bit  stim_done = 1'b0;

	vector_normalize_3d_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_in(x_in), .y_in(y_in), .z_in(z_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_out(x_out), .y_out(y_out), .z_out(z_out), .ok(ok)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// largest k with (2k-1)^2 * sum <= 4 * mag^2 * 2^(2*FRAC_BITS)
	function automatic logic [OUT_WIDTH-1:0] round_unit(logic [IN_WIDTH:0] mag,
			logic [SUM_WIDTH+1:0] sum, bit neg);
		logic [127:0] rhs, lhs;
		logic [63:0] t;
		longint unsigned lo, hi, k;
		rhs = (128'(mag) * 128'(mag)) << (2 * FRAC_BITS + 2);
		lo = 0;
		hi = 64'd1 << FRAC_BITS;
		while (lo < hi) begin
			k = (lo + hi + 1) >> 1;
			t = 2 * k - 1;
			lhs = 128'(t) * 128'(t) * 128'(sum);
			if (lhs <= rhs)
				lo = k;
			else
				hi = k - 1;
		end
		return neg ? OUT_WIDTH'(-lo) : OUT_WIDTH'(lo);
	endfunction

	function automatic unit_vec_t normalise(logic [IN_WIDTH-1:0] x, logic [IN_WIDTH-1:0] y,
			logic [IN_WIDTH-1:0] z);
		logic [IN_WIDTH:0] mx, my, mz;
		logic [SUM_WIDTH+1:0] sum;
		unit_vec_t r;
		// magnitude in one extra bit so the most negative input stays positive
		mx = x[IN_WIDTH-1] ? ({1'b0, ~x} + 1'b1) : {1'b0, x};
		my = y[IN_WIDTH-1] ? ({1'b0, ~y} + 1'b1) : {1'b0, y};
		mz = z[IN_WIDTH-1] ? ({1'b0, ~z} + 1'b1) : {1'b0, z};
		sum = mx * mx + my * my + mz * mz;
		if (sum == 0)
			return '0;
		r.x = round_unit(mx, sum, x[IN_WIDTH-1]);
		r.y = round_unit(my, sum, y[IN_WIDTH-1]);
		r.z = round_unit(mz, sum, z[IN_WIDTH-1]);
		r.ok = 1'b1;
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one word on the input channel; valid held until taken
	task automatic send_vector(logic [IN_WIDTH-1:0] x, logic [IN_WIDTH-1:0] y,
			logic [IN_WIDTH-1:0] z, bit fixed, unit_vec_t exp);
		in_valid <= 1'b1;
		x_in <= x;
		y_in <= y;
		z_in <= z;
		expected_words.push_back(fixed ? exp : normalise(x, y, z));
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	task automatic drive_word(logic [IN_WIDTH-1:0] x, logic [IN_WIDTH-1:0] y,
			logic [IN_WIDTH-1:0] z, bit fixed, unit_vec_t exp);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		send_vector(x, y, z, fixed, exp);
	endtask

	function automatic logic [IN_WIDTH-1:0] rand_comp();
		int p;
		p = $urandom_range(0, 9);
		unique case (p)
			0: return '0;
			1: return {1'b1, {(IN_WIDTH-1){1'b0}}};
			2: return {1'b0, {(IN_WIDTH-1){1'b1}}};
			3: return IN_WIDTH'($signed($urandom_range(0, 15)) - 8);
			default: return IN_WIDTH'($urandom);
		endcase
	endfunction

	// receiver: random stalls, checks against the oldest expectation
	always @(posedge clk) begin
		unit_vec_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: x %0d y %0d z %0d ok %0b", x_out, y_out, z_out, ok);
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (x_out !== e.x) begin
						$error("x_out expected %0d actual %0d", $signed(e.x), x_out);
						errors++;
					end
					if (y_out !== e.y) begin
						$error("y_out expected %0d actual %0d", $signed(e.y), y_out);
						errors++;
					end
					if (z_out !== e.z) begin
						$error("z_out expected %0d actual %0d", $signed(e.z), z_out);
						errors++;
					end
					if (ok !== e.ok) begin
						$error("ok expected %0b actual %0b", e.ok, ok);
						errors++;
					end
				end
				words_checked++;
			end
			out_ready <= stall_hold ? 1'b0 :
				($urandom_range(0, 99) < 8) ? 1'b0 : ($urandom_range(0, 99) < 70);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// long receiver stalls now and then
	initial begin
		wait (arst_n);
		while (!stim_done) begin
			repeat ($urandom_range(200, 600)) @(posedge clk);
			force_stall();
		end
	end

	task automatic force_stall();
		// receiver holds off for a long stretch
		int n;
		n = $urandom_range(20, 60);
		stall_hold <= 1'b1;
		repeat (n) @(posedge clk);
		stall_hold <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		localparam logic [IN_WIDTH-1:0] MAXP = {1'b0, {(IN_WIDTH-1){1'b1}}};
		localparam logic [IN_WIDTH-1:0] MAXN = {1'b1, {(IN_WIDTH-1){1'b0}}};
		localparam logic [IN_WIDTH-1:0] M1 = '1;
		stim_row_t rows[$];
		unit_vec_t zero_word;
		unit_vec_t sx, snx, sy, sny, sz, snz;
		int lx, ly, lz;
		zero_word = '0;
		sx = '{x: ONE_FX, y: '0, z: '0, ok: 1'b1};
		snx = '{x: -ONE_FX, y: '0, z: '0, ok: 1'b1};
		sy = '{x: '0, y: ONE_FX, z: '0, ok: 1'b1};
		sny = '{x: '0, y: -ONE_FX, z: '0, ok: 1'b1};
		sz = '{x: '0, y: '0, z: ONE_FX, ok: 1'b1};
		snz = '{x: '0, y: '0, z: -ONE_FX, ok: 1'b1};
		rows = '{
			'{'0, '0, '0, 1'b1, zero_word},
			'{16'd1, '0, '0, 1'b1, sx},
			'{M1, '0, '0, 1'b1, snx},
			'{MAXP, '0, '0, 1'b1, sx},
			'{MAXN, '0, '0, 1'b1, snx},
			'{'0, MAXP, '0, 1'b1, sy},
			'{'0, MAXN, '0, 1'b1, sny},
			'{'0, '0, MAXP, 1'b1, sz},
			'{'0, '0, MAXN, 1'b1, snz},
			'{'0, '0, 16'd5, 1'b1, sz},
			'{MAXN, MAXN, MAXN, 1'b0, zero_word},
			'{MAXP, MAXP, MAXP, 1'b0, zero_word},
			'{MAXP, MAXN, MAXP, 1'b0, zero_word},
			'{16'd1, 16'd1, 16'd1, 1'b0, zero_word},
			'{M1, 16'd1, M1, 1'b0, zero_word},
			'{16'd3, 16'd4, '0, 1'b0, zero_word},
			'{'0, M1, 16'd1, 1'b0, zero_word},
			'{16'd1, MAXP, '0, 1'b0, zero_word},
			'{16'd2, 16'd1, 16'd2, 1'b0, zero_word},
			'{16'h5555, 16'hAAAA, 16'h00FF, 1'b0, zero_word},
			'{16'hAAAA, 16'h5555, 16'hFF00, 1'b0, zero_word}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			drive_word(rows[i].x, rows[i].y, rows[i].z, rows[i].fixed, rows[i].exp);

		for (int n = 0; n < N_RANDOM; n++) begin
			// hold off until the pipeline has drained, once
			if (n == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				wait (expected_words.size() == 0);
				@(posedge clk);
			end
			// bursts with no gaps in places
			if (n >= 300 && n < 400)
				send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, zero_word);
			else
				drive_word(rand_comp(), rand_comp(), rand_comp(), 1'b0, zero_word);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;

		wait (expected_words.size() == 0);
		repeat (NSTAGE + 10) @(posedge clk);
		$display("sent %0d vectors (directed extremes, axes, zero vector, random mix)",
			words_sent);
		$display("checked %0d normalised words under random gaps and stalls", words_checked);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
